[rtl/fmr_pkg.sv]
// shared types, codes and default sizes for the framed message receiver
// no dependencies
package fmr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF    = 25;
  localparam int unsigned FRAME_OVERHEAD_DEF = 5;
  localparam int unsigned BYTE_MAX           = 255;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_TIMEOUT  = 3'd1,
    STAT_BAD_SUM  = 3'd2,
    STAT_NO_END   = 3'd3,
    STAT_TOO_LONG = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START   = 2'd0,
    CFG_END     = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CSUM = 3'd4,
    PH_END  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'd0,
    SEQ_DIV  = 3'd1,
    SEQ_SOLO = 3'd2,
    SEQ_READ = 3'd3,
    SEQ_EMIT = 3'd4
  } seq_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

[rtl/fmr_rem_unit.sv]
// iterative restoring remainder unit, one quotient bit per cycle
// depends on fmr_pkg
module fmr_rem_unit #(
  parameter int unsigned SUM_W = 13,
  parameter int unsigned DIV_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SUM_W-1:0]     dividend_i,
  input  logic [DIV_W-1:0]     divisor_i,
  output fmr_pkg::rem_stat_t   stat_o,
  output logic [DIV_W-1:0]     rem_o
);
  import fmr_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W:0]   trial;

  assign trial = {rem_q, dvd_q[SUM_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = DIV_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

[rtl/fmr_pay_mem.sv]
// payload byte store, one write and one registered read per cycle
// depends on fmr_pkg
module fmr_pay_mem #(
  parameter int unsigned DEPTH  = 25,
  parameter int unsigned ADDR_W = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [fmr_pkg::BYTE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [fmr_pkg::BYTE_W-1:0] rdata_o
);
  import fmr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/framed_message_receiver.sv]
// top level of the framed message receiver: frame parser, sequencer, output register
// depends on fmr_pkg, fmr_rem_unit and fmr_pay_mem
//
// Takes received bytes and timer ticks one transfer at a time and parses
// frames of start, type, length, payload, checksum and end byte. The end
// byte of a frame whose sum exceeds 255 holds the input while the
// shift-subtract remainder unit works through the running sum bit by bit
// (13 bits at the default payload limit). A good frame then unloads its
// payload through the registered read port of the payload memory, each byte
// read and then emitted; a single result (error or empty frame) is loaded
// directly. Input is not taken while results are produced, and each result
// waits for the output register to be free, so a result still held there
// stalls the sequencer; a held result alone never stops the next byte.
// No clearing pass after reset.
module framed_message_receiver #(
  parameter int unsigned MAX_PAYLOAD    = fmr_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned FRAME_OVERHEAD = fmr_pkg::FRAME_OVERHEAD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fmr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fmr_pkg::TICK_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [fmr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fmr_pkg::STATUS_W-1:0]  status_o,
  output logic [fmr_pkg::BYTE_W-1:0]    msg_type_o,
  output logic [fmr_pkg::LEN_W-1:0]     payload_len_o,
  output logic [fmr_pkg::BYTE_W-1:0]    data_byte_o,
  output logic [fmr_pkg::LEN_W-1:0]     byte_index_o,
  output logic                          data_valid_o,
  output logic                          last_o
);
  import fmr_pkg::*;

  localparam int unsigned LEN_IW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned SUM_W  = $clog2(BYTE_MAX * (MAX_PAYLOAD + 2) + 1);
  localparam int unsigned DIV_W  = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);

  // configuration
  logic [BYTE_W-1:0] start_q, end_q;
  logic [TICK_W-1:0] timeout_q;

  // frame state
  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [LEN_IW-1:0] len_q, len_d;
  logic [LEN_IW-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [BYTE_W-1:0] csum_q, csum_d;
  logic [TICK_W-1:0] tick_q, tick_d;

  // sequencer
  seq_e              seq_q, seq_d;
  seq_e              item_seq, div_seq;
  status_e           stat_q, stat_d;
  logic [LEN_IW-1:0] emit_q, emit_d;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              emit_last;
  logic [TICK_W:0]   tick_next;
  logic [LEN_IW-1:0] cnt_inc;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_rdata;
  logic              div_start;
  rem_stat_t         rem_stat;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;

  // output register
  logic              out_valid_q;
  status_e           o_stat_q;
  logic [BYTE_W-1:0] o_type_q, o_data_q;
  logic [LEN_W-1:0]  o_len_q, o_idx_q;
  logic              o_dvalid_q, o_last_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (seq_q == SEQ_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign tick_next   = {1'b0, tick_q} + (TICK_W+1)'(1);
  assign cnt_inc     = cnt_q + LEN_IW'(1);
  assign divisor     = DIV_W'(len_q) + DIV_W'(FRAME_OVERHEAD);
  assign emit_last   = ((emit_q + LEN_IW'(1)) == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= BYTE_W'(2);
      end_q     <= BYTE_W'(3);
      timeout_q <= TICK_W'(100);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START:   start_q   <= cfg_data_i[BYTE_W-1:0];
        CFG_END:     end_q     <= cfg_data_i[BYTE_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // frame parsing and datapath updates
  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    csum_d    = csum_q;
    tick_d    = tick_q;
    stat_d    = stat_q;
    emit_d    = emit_q;
    item_seq  = SEQ_IDLE;
    div_seq   = SEQ_SOLO;
    mem_we    = 1'b0;
    div_start = 1'b0;
    if ((seq_q == SEQ_IDLE) && in_fire) begin
      if (req_type_i) begin
        if (phase_q != PH_HUNT) begin
          if (tick_next > {1'b0, timeout_q}) begin
            stat_d   = STAT_TIMEOUT;
            phase_d  = PH_HUNT;
            item_seq = SEQ_SOLO;
          end else begin
            tick_d = tick_next[TICK_W-1:0];
          end
        end
      end else begin
        case (phase_q)
          PH_HUNT: begin
            if (rx_byte_i == start_q) begin
              phase_d = PH_TYPE;
              type_d  = '0;
              len_d   = '0;
              cnt_d   = '0;
              sum_d   = '0;
              csum_d  = '0;
              tick_d  = '0;
            end
          end
          PH_TYPE: begin
            type_d  = rx_byte_i;
            sum_d   = SUM_W'(rx_byte_i);
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (rx_byte_i > BYTE_W'(MAX_PAYLOAD)) begin
              stat_d   = STAT_TOO_LONG;
              phase_d  = PH_HUNT;
              item_seq = SEQ_SOLO;
            end else begin
              len_d   = LEN_IW'(rx_byte_i);
              sum_d   = sum_q + SUM_W'(rx_byte_i);
              cnt_d   = '0;
              tick_d  = '0;
              phase_d = (rx_byte_i == '0) ? PH_CSUM : PH_DATA;
            end
          end
          PH_DATA: begin
            mem_we = 1'b1;
            sum_d  = sum_q + SUM_W'(rx_byte_i);
            cnt_d  = cnt_inc;
            if (cnt_inc >= len_q) begin
              phase_d = PH_CSUM;
            end
          end
          PH_CSUM: begin
            csum_d  = rx_byte_i;
            phase_d = PH_END;
          end
          PH_END: begin
            phase_d = PH_HUNT;
            if (rx_byte_i != end_q) begin
              stat_d   = STAT_NO_END;
              item_seq = SEQ_SOLO;
            end else if (sum_q > SUM_W'(BYTE_MAX)) begin
              div_start = 1'b1;
              item_seq  = SEQ_DIV;
            end else if (sum_q == SUM_W'(csum_q)) begin
              stat_d   = STAT_OK;
              emit_d   = '0;
              item_seq = (len_q == '0) ? SEQ_SOLO : SEQ_READ;
            end else begin
              stat_d   = STAT_BAD_SUM;
              item_seq = SEQ_SOLO;
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end else if ((seq_q == SEQ_DIV) && rem_stat.done) begin
      if (SUM_W'(rem) == SUM_W'(csum_q)) begin
        stat_d  = STAT_OK;
        emit_d  = '0;
        div_seq = (len_q == '0) ? SEQ_SOLO : SEQ_READ;
      end else begin
        stat_d  = STAT_BAD_SUM;
        div_seq = SEQ_SOLO;
      end
    end else if ((seq_q == SEQ_EMIT) && out_free) begin
      emit_d = emit_q + LEN_IW'(1);
    end
  end

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_IDLE: if (in_fire) seq_d = item_seq;
      SEQ_DIV:  if (rem_stat.done) seq_d = div_seq;
      SEQ_SOLO: if (out_free) seq_d = SEQ_IDLE;
      SEQ_READ: seq_d = SEQ_EMIT;
      SEQ_EMIT: if (out_free) seq_d = emit_last ? SEQ_IDLE : SEQ_READ;
      default:  seq_d = SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    case (seq_q)
      SEQ_SOLO: out_load = out_free;
      SEQ_EMIT: out_load = out_free;
      default:  out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      phase_q     <= PH_HUNT;
      type_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      csum_q      <= '0;
      tick_q      <= '0;
      stat_q      <= STAT_OK;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      csum_q  <= csum_d;
      tick_q  <= tick_d;
      stat_q  <= stat_d;
      emit_q  <= emit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_type_q <= type_q;
      o_len_q  <= LEN_W'(len_q);
      if (seq_q == SEQ_EMIT) begin
        o_stat_q   <= STAT_OK;
        o_data_q   <= mem_rdata;
        o_idx_q    <= LEN_W'(emit_q);
        o_dvalid_q <= 1'b1;
        o_last_q   <= emit_last;
      end else begin
        o_stat_q   <= stat_q;
        o_data_q   <= '0;
        o_idx_q    <= '0;
        o_dvalid_q <= 1'b0;
        o_last_q   <= 1'b1;
      end
    end
  end

  fmr_rem_unit #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (divisor),
    .stat_o     (rem_stat),
    .rem_o      (rem)
  );

  fmr_pay_mem #(
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (emit_q[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_stat_q;
  assign msg_type_o    = o_type_q;
  assign payload_len_o = o_len_q;
  assign data_byte_o   = o_data_q;
  assign byte_index_o  = o_idx_q;
  assign data_valid_o  = o_dvalid_q;
  assign last_o        = o_last_q;

  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_valid_o) |-> (status_o == STAT_OK))
    else $error("payload byte carries an error status");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_stat.done |-> (seq_q == SEQ_DIV))
    else $error("remainder finished outside the divide step");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((seq_q == SEQ_READ) || (seq_q == SEQ_EMIT)) |-> (emit_q < len_q))
    else $error("emit index beyond frame length");

  a_hunt_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SEQ_IDLE) |-> (phase_q == PH_HUNT))
    else $error("frame parsing active while results are produced");

endmodule

[bench/tb_framed_message_receiver.sv]
// testbench for framed_message_receiver: queue-fed driver, clocked monitor, own frame parser
// depends on fmr_pkg and the framed_message_receiver rtl
module tb_framed_message_receiver;
  import fmr_pkg::*;

  localparam int MAX_PAYLOAD    = MAX_PAYLOAD_DEF;
  localparam int FRAME_OVERHEAD = FRAME_OVERHEAD_DEF;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] value;
  } rx_item_t;

  typedef struct {
    status_e    status;
    logic [7:0] msg_type;
    logic [4:0] payload_len;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       data_valid;
    logic       is_last;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_req = 1'b0;
  logic [7:0]           in_byte = '0;
  logic                 out_ready = 1'b0;

  logic                cfg_ready_o;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [7:0]          msg_type_o;
  logic [4:0]          payload_len_o;
  logic [7:0]          data_byte_o;
  logic [4:0]          byte_index_o;
  logic                data_valid_o;
  logic                last_o;

  // expected frame parser state and register copies
  logic [7:0]  cur_start = 8'd2;
  logic [7:0]  cur_end = 8'd3;
  logic [15:0] cur_timeout = 16'd100;
  phase_e      p_phase = PH_HUNT;
  logic [7:0]  p_type = '0;
  logic [4:0]  p_len = '0;
  int          p_count = 0;
  int          p_sum = 0;
  logic [7:0]  p_csum = '0;
  int          p_ticks = 0;
  logic [7:0]  p_store [MAX_PAYLOAD];

  rx_item_t      rx_pending_q [$];
  frame_result_t awaited_results [$];
  rx_item_t      nxt_item;
  int            in_gap = 0;
  int            out_stall = 0;
  int            idle_cycles = 0;
  int            fail_count = 0;
  logic          quiet = 1'b0;

  framed_message_receiver u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .req_type_i    (in_req),
    .rx_byte_i     (in_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .status_o      (status_o),
    .msg_type_o    (msg_type_o),
    .payload_len_o (payload_len_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .data_valid_o  (data_valid_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void push_result(status_e st, logic [7:0] data, logic [4:0] idx,
                                      logic dv, logic lst);
    frame_result_t r;
    r.status      = st;
    r.msg_type    = p_type;
    r.payload_len = p_len;
    r.data_byte   = data;
    r.byte_index  = idx;
    r.data_valid  = dv;
    r.is_last     = lst;
    awaited_results.push_back(r);
  endfunction

  function automatic void abort_frame(status_e st);
    push_result(st, 8'd0, 5'd0, 1'b0, 1'b1);
    p_phase = PH_HUNT;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      CFG_START:   cur_start = val[7:0];
      CFG_END:     cur_end = val[7:0];
      CFG_TIMEOUT: cur_timeout = val;
      default: ;
    endcase
  endfunction

  function automatic void parse_rx_item(logic is_tick, logic [7:0] b);
    int sum;
    if (is_tick) begin
      if (p_phase != PH_HUNT) begin
        if (p_ticks + 1 > int'(cur_timeout)) abort_frame(STAT_TIMEOUT);
        else p_ticks++;
      end
    end else begin
      case (p_phase)
        PH_HUNT: begin
          if (b == cur_start) begin
            p_phase = PH_TYPE;
            p_type  = '0;
            p_len   = '0;
            p_count = 0;
            p_sum   = 0;
            p_csum  = '0;
            p_ticks = 0;
          end
        end
        PH_TYPE: begin
          p_type  = b;
          p_sum   = int'(b);
          p_phase = PH_LEN;
        end
        PH_LEN: begin
          if (int'(b) > MAX_PAYLOAD) begin
            abort_frame(STAT_TOO_LONG);
          end else begin
            p_len   = b[4:0];
            p_sum  += int'(b);
            p_count = 0;
            p_ticks = 0;
            p_phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          if (p_count < MAX_PAYLOAD) p_store[p_count] = b;
          p_sum += int'(b);
          p_count++;
          if (p_count >= int'(p_len)) p_phase = PH_CSUM;
        end
        PH_CSUM: begin
          p_csum  = b;
          p_phase = PH_END;
        end
        PH_END: begin
          sum = p_sum;
          if (b != cur_end) begin
            abort_frame(STAT_NO_END);
          end else begin
            if (sum > BYTE_MAX) sum = sum % (int'(p_len) + FRAME_OVERHEAD);
            if (sum != int'(p_csum)) begin
              abort_frame(STAT_BAD_SUM);
            end else begin
              p_phase = PH_HUNT;
              if (p_len == 5'd0) push_result(STAT_OK, 8'd0, 5'd0, 1'b0, 1'b1);
              else
                for (int k = 0; k < int'(p_len); k++)
                  push_result(STAT_OK, p_store[k], k[4:0], 1'b1, (k + 1 == int'(p_len)));
            end
          end
        end
        default: p_phase = PH_HUNT;
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, status %0d", status_o));
    end else begin
      want = awaited_results.pop_front();
      if (status_o !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      if (msg_type_o !== want.msg_type)
        report_mismatch($sformatf("msg_type %0h, want %0h", msg_type_o, want.msg_type));
      if (payload_len_o !== want.payload_len)
        report_mismatch($sformatf("payload_len %0d, want %0d", payload_len_o, want.payload_len));
      if (data_byte_o !== want.data_byte)
        report_mismatch($sformatf("data_byte %0h, want %0h", data_byte_o, want.data_byte));
      if (byte_index_o !== want.byte_index)
        report_mismatch($sformatf("byte_index %0d, want %0d", byte_index_o, want.byte_index));
      if (data_valid_o !== want.data_valid)
        report_mismatch($sformatf("data_valid %0b, want %0b", data_valid_o, want.data_valid));
      if (last_o !== want.is_last)
        report_mismatch($sformatf("last %0b, want %0b", last_o, want.is_last));
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= 1'b0;
      in_byte  <= '0;
      in_gap = 0;
    end else if (!in_valid || in_ready_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (rx_pending_q.size() != 0) begin
        nxt_item = rx_pending_q.pop_front();
        in_valid <= 1'b1;
        in_req   <= nxt_item.is_tick;
        in_byte  <= nxt_item.value;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready_o) parse_rx_item(in_req, in_byte);
      if (out_valid_o && out_ready) check_result();
      if ((cfg_valid && cfg_ready_o) || (in_valid && in_ready_o) || (out_valid_o && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_framed_message_receiver: FAIL");
        $finish;
      end
    end
  end

  task automatic add_item(input logic is_tick, input logic [7:0] v);
    rx_item_t it;
    it.is_tick = is_tick;
    it.value   = v;
    rx_pending_q.push_back(it);
  endtask

  task automatic maybe_tick(input int pct);
    if ($urandom_range(0, 99) < pct) add_item(1'b1, 8'($urandom));
  endtask

  task automatic add_frame(input int force_len, input int tick_pct);
    int len;
    int sum;
    int flaw;
    logic [7:0] ty;
    logic [7:0] pay;
    logic [7:0] csum;
    flaw = $urandom_range(0, 9);
    ty   = 8'($urandom);
    if (force_len >= 0) begin
      len = force_len;
    end else begin
      case ($urandom_range(0, 19))
        0, 1:    len = 0;
        2:       len = MAX_PAYLOAD;
        3:       len = $urandom_range(MAX_PAYLOAD + 1, 255);
        default: len = $urandom_range(1, 8);
      endcase
    end
    add_item(1'b0, cur_start);
    maybe_tick(tick_pct);
    add_item(1'b0, ty);
    maybe_tick(tick_pct);
    add_item(1'b0, len[7:0]);
    if (len <= MAX_PAYLOAD) begin
      sum = int'(ty) + len;
      for (int k = 0; k < len; k++) begin
        pay  = 8'($urandom);
        sum += int'(pay);
        maybe_tick(tick_pct);
        add_item(1'b0, pay);
      end
      if (sum > BYTE_MAX) sum = sum % (len + FRAME_OVERHEAD);
      csum = sum[7:0];
      if (flaw == 0) csum = csum ^ 8'($urandom_range(1, 255));
      maybe_tick(tick_pct);
      add_item(1'b0, csum);
      add_item(1'b0, (flaw == 1) ? (cur_end ^ 8'($urandom_range(1, 255))) : cur_end);
    end
  endtask

  task automatic add_random_part(input int n_items, input int tick_pct);
    int goal;
    goal = rx_pending_q.size() + n_items;
    while (rx_pending_q.size() < goal) begin
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 4)) add_item(1'($urandom_range(0, 1)), 8'($urandom));
      else
        add_frame(-1, tick_pct);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (rx_pending_q.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] first_frames [$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty frame at sum 255, over-long length, wrong end byte, bad checksum,
    // reduced sum with the start byte inside the frame
    first_frames = '{8'h02, 8'hFF, 8'h00, 8'hFF, 8'h03,
                     8'h02, 8'h00, 8'h1A,
                     8'h02, 8'h01, 8'h01, 8'hAA, 8'hAC, 8'h04,
                     8'h02, 8'h80, 8'h00, 8'h81, 8'h03,
                     8'h02, 8'hFF, 8'h02, 8'h02, 8'h10, 8'h02, 8'h03};
    add_item(1'b1, 8'h5A);
    foreach (first_frames[k]) add_item(1'b0, first_frames[k]);
    wait_idle();

    write_reg(CFG_START, {8'($urandom), 8'h00});
    write_reg(CFG_END, {8'($urandom), 8'hFF});
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_UNUSED, 16'hFFFF);
    add_item(1'b0, 8'h00);
    add_item(1'b1, 8'hA5);
    add_item(1'b1, 8'h5A);
    add_random_part(20, 5);
    wait_idle();

    write_reg(CFG_START, {8'($urandom), 8'hFF});
    write_reg(CFG_END, {8'($urandom), 8'h00});
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    add_frame(MAX_PAYLOAD, 30);
    add_random_part(30, 30);
    wait_idle();

    write_reg(CFG_START, 16'($urandom));
    write_reg(CFG_END, 16'($urandom));
    write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 6)));
    add_random_part(25, 20);
    wait_idle();

    quiet = 1'b1;
    write_reg(CFG_START, 16'($urandom));
    write_reg(CFG_END, 16'($urandom));
    write_reg(CFG_TIMEOUT, 16'd100);
    add_frame(MAX_PAYLOAD, 10);
    add_random_part(20, 10);
    wait_idle();

    if (fail_count == 0) begin
      $display("tb_framed_message_receiver: PASS");
    end else begin
      $display("tb_framed_message_receiver: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fmr_pkg.sv
rtl/fmr_rem_unit.sv
rtl/fmr_pay_mem.sv
rtl/framed_message_receiver.sv
bench/tb_framed_message_receiver.sv
